// ===== design/checked_handle_table_defines.svh =====
// ----------------------------------------------------------------------------
// checked_handle_table_defines
// Assertion macros shared by the checked handle table checker.
// ----------------------------------------------------------------------------
`ifndef CHECKED_HANDLE_TABLE_DEFINES_SVH
`define CHECKED_HANDLE_TABLE_DEFINES_SVH

// same-cycle implication, clocked and disabled in reset
`define CHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked and disabled in reset
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Constants and codes of the checked handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

	localparam int TABLE_DEPTH  = 128;
	localparam int IDENT_WIDTH  = 32;
	localparam int OBJECT_WIDTH = 64;
	localparam int SLOT_W       = 7;
	localparam int FUNC_W       = 2;
	localparam int STATUS_W     = 2;

	localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_DETACHED = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== design/cht_ram.sv =====
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/cht_free_enc.sv =====
// ----------------------------------------------------------------------------
// cht_free_enc
// Registered lowest-free-slot encoder over the occupancy bits.
// Gives DEPTH when every slot is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_free_enc #(
	parameter int DEPTH = 128,
	parameter int FW    = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [DEPTH-1:0] valid,
	output logic      [FW-1:0]    free_q
);

	logic [DEPTH-1:0] free_bits;
	logic [DEPTH-1:0] lowest;
	logic [FW-1:0]    enc;

	always_comb begin
		free_bits = ~valid;
		lowest    = free_bits & (~free_bits + DEPTH'(1));
		enc       = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lowest[i]) begin
				enc = enc | FW'(i);
			end
		end
		if (free_bits == '0) begin
			enc = FW'(DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else begin
			free_q <= enc;
		end
	end

endmodule

`default_nettype wire

// ===== design/checked_handle_table.sv =====
// ----------------------------------------------------------------------------
// checked_handle_table
// Handle table: create, look up and remove objects by (slot, id) handles.
//
//   channel   handshake          payload
//   command   start / busy       func, object_value, slot_index, handle_ident
//   result    done (strobe)      result_object, new_ident, new_slot, status
//
// For each command, the accepting edge issues the table read, and
// the next edge writes back and registers the result, shown with done for the
// following cycle while a new command may already be accepted.
// The pace is set by the read-modify-write on the table memory, whose read is registered.
// Reset clears all occupancy bits at once; no clearing pass is needed.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_handle_table #(
	parameter int TABLE_DEPTH  = cht_pkg::TABLE_DEPTH,
	parameter int IDENT_WIDTH  = cht_pkg::IDENT_WIDTH,
	parameter int OBJECT_WIDTH = cht_pkg::OBJECT_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [cht_pkg::FUNC_W-1:0]  func,
	input  wire logic [OBJECT_WIDTH-1:0]     object_value,
	input  wire logic [cht_pkg::SLOT_W-1:0]  slot_index,
	input  wire logic [IDENT_WIDTH-1:0]      handle_ident,
	output logic                             done,
	output logic [OBJECT_WIDTH-1:0]          result_object,
	output logic [IDENT_WIDTH-1:0]           new_ident,
	output logic [cht_pkg::SLOT_W-1:0]       new_slot,
	output logic [cht_pkg::STATUS_W-1:0]     status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = IDENT_WIDTH + OBJECT_WIDTH;

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t                        state_q;
	logic                          accept;
	logic [cht_pkg::FUNC_W-1:0]    func_s1;
	logic [OBJECT_WIDTH-1:0]       obj_s1;
	logic [cht_pkg::SLOT_W-1:0]    idx_s1;
	logic [IDENT_WIDTH-1:0]        id_s1;
	logic [TABLE_DEPTH-1:0]        valid_q;
	logic [IDENT_WIDTH-1:0]        ident_q;
	logic [IDENT_WIDTH-1:0]        ident_inc;
	logic [FW-1:0]                 free_q;
	logic [RW-1:0]                 rdata;
	logic [IDENT_WIDTH-1:0]        rd_ident;
	logic [OBJECT_WIDTH-1:0]       rd_obj;
	logic                          in_range;
	logic                          hit;
	logic                          full;
	logic                          we;
	logic                          clr_v;
	logic [OBJECT_WIDTH-1:0]       res_obj;
	logic [IDENT_WIDTH-1:0]        res_id;
	logic [cht_pkg::SLOT_W-1:0]    res_slot;
	cht_pkg::status_t              res_st;

	assign accept = start && !busy;
	assign busy   = (state_q == EXEC);

	cht_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(free_q)),
		.wdata({obj_s1, ident_q}),
		.re   (accept),
		.raddr(AW'(slot_index)),
		.rdata(rdata)
	);

	cht_free_enc #(
		.DEPTH(TABLE_DEPTH),
		.FW   (FW)
	) u_free_enc (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (valid_q),
		.free_q(free_q)
	);

	assign rd_ident  = rdata[IDENT_WIDTH-1:0];
	assign rd_obj    = rdata[RW-1:IDENT_WIDTH];
	assign in_range  = (32'(idx_s1) < 32'(TABLE_DEPTH));
	assign hit       = in_range && valid_q[AW'(idx_s1)] && (rd_ident == id_s1);
	assign full      = (free_q == FW'(TABLE_DEPTH));
	assign ident_inc = ident_q + IDENT_WIDTH'(1);

	always_comb begin
		res_obj  = '0;
		res_id   = '0;
		res_slot = '0;
		res_st   = cht_pkg::ST_MISMATCH;
		we       = 1'b0;
		clr_v    = 1'b0;
		if (state_q == EXEC) begin
			unique case (func_s1)
				cht_pkg::FUNC_CREATE: begin
					if (full) begin
						res_st = cht_pkg::ST_FULL;
					end else begin
						we       = 1'b1;
						res_id   = ident_q;
						res_slot = cht_pkg::SLOT_W'(free_q);
						res_st   = cht_pkg::ST_OK;
					end
				end
				cht_pkg::FUNC_LOOKUP: begin
					if (id_s1 == '0) begin
						res_st = cht_pkg::ST_DETACHED;
					end else if (hit) begin
						res_obj = rd_obj;
						res_st  = cht_pkg::ST_OK;
					end
				end
				cht_pkg::FUNC_REMOVE: begin
					if (hit) begin
						clr_v   = 1'b1;
						res_obj = rd_obj;
						res_st  = cht_pkg::ST_OK;
					end
				end
				default: begin
					res_st = cht_pkg::ST_MISMATCH;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			valid_q       <= '0;
			ident_q       <= IDENT_WIDTH'(1);
			func_s1       <= '0;
			obj_s1        <= '0;
			idx_s1        <= '0;
			id_s1         <= '0;
			done          <= 1'b0;
			result_object <= '0;
			new_ident     <= '0;
			new_slot      <= '0;
			status        <= '0;
		end else begin
			done <= (state_q == EXEC);
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						func_s1 <= func;
						obj_s1  <= object_value;
						idx_s1  <= slot_index;
						id_s1   <= handle_ident;
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (we) begin
						valid_q[AW'(free_q)] <= 1'b1;
						ident_q <= (ident_inc == '0) ? IDENT_WIDTH'(1) : ident_inc;
					end
					if (clr_v) begin
						valid_q[AW'(idx_s1)] <= 1'b0;
					end
					result_object <= res_obj;
					new_ident     <= res_id;
					new_slot      <= res_slot;
					status        <= res_st;
					state_q       <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/cht_checker.sv =====
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks on the checked handle table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "checked_handle_table_defines.svh"

module cht_checker #(
	parameter int IDENT_WIDTH  = cht_pkg::IDENT_WIDTH,
	parameter int OBJECT_WIDTH = cht_pkg::OBJECT_WIDTH
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [OBJECT_WIDTH-1:0]     result_object,
	input wire logic [IDENT_WIDTH-1:0]      new_ident,
	input wire logic [cht_pkg::SLOT_W-1:0]  new_slot,
	input wire logic [cht_pkg::STATUS_W-1:0] status
);

	`CHT_ASSERT_SAME(a_beat_done, clk, arst_n, start && !busy, ##2 done, "command beat without result two cycles later")
	`CHT_ASSERT_NEXT(a_busy_once, clk, arst_n, busy, !busy && done, "busy longer than one cycle or no result")
	`CHT_ASSERT_SAME(a_full_zero, clk, arst_n, done && (status == cht_pkg::ST_FULL), (result_object == '0) && (new_ident == '0) && (new_slot == '0), "full result carries nonzero fields")
	`CHT_ASSERT_SAME(a_fail_noid, clk, arst_n, done && (status != cht_pkg::ST_OK), new_ident == '0, "failed command handed out an id")

endmodule

bind checked_handle_table cht_checker #(
	.IDENT_WIDTH (IDENT_WIDTH),
	.OBJECT_WIDTH(OBJECT_WIDTH)
) u_cht_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_object(result_object),
	.new_ident    (new_ident),
	.new_slot     (new_slot),
	.status       (status)
);

`default_nettype wire

// ===== tb/checked_handle_table_test.sv =====
// ----------------------------------------------------------------------------
// checked_handle_table_test
// Self-checking bench for the checked handle table. A generator fills a
// queue with a short directed run and then random create, look-up and remove
// traffic that alternately fills the table past full and drains it. A clocked
// driver issues the commands on start/busy, with random idle cycles. A clocked
// monitor keeps its own copy of the table, predicts every reply at acceptance
// and compares each done beat against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_handle_table_test;

	timeunit 1ns;
	timeprecision 1ps;

	import cht_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_COMMANDS = 828;

	typedef struct {
		logic [FUNC_W-1:0]       func;
		logic [OBJECT_WIDTH-1:0] object_word;
		logic [SLOT_W-1:0]       slot;
		logic [IDENT_WIDTH-1:0]  ident;
		int unsigned             idle_pct;
	} table_command_t;

	typedef struct {
		logic [OBJECT_WIDTH-1:0] object_word;
		logic [IDENT_WIDTH-1:0]  ident;
		logic [SLOT_W-1:0]       slot;
		status_t                 status;
	} table_reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [FUNC_W-1:0]       func = FUNC_CREATE;
	logic [OBJECT_WIDTH-1:0] object_value = '0;
	logic [SLOT_W-1:0]       slot_index = '0;
	logic [IDENT_WIDTH-1:0]  handle_ident = '0;
	logic                    busy;
	logic                    done;
	logic [OBJECT_WIDTH-1:0] result_object;
	logic [IDENT_WIDTH-1:0]  new_ident;
	logic [SLOT_W-1:0]       new_slot;
	logic [STATUS_W-1:0]     status;

	table_command_t pending_commands[$];
	table_command_t next_command;
	table_reply_t   expected_replies[$];

	// predicted table contents
	bit                      occupied[TABLE_DEPTH];
	bit                      ever_written[TABLE_DEPTH];
	logic [IDENT_WIDTH-1:0]  stored_ident[TABLE_DEPTH];
	logic [OBJECT_WIDTH-1:0] stored_object[TABLE_DEPTH];
	int unsigned             lowest_free = 0;
	int unsigned             occupied_count = 0;
	int unsigned             full_rejects = 0;
	logic [IDENT_WIDTH-1:0]  next_ident = 1;

	int unsigned mismatch_count = 0;
	int unsigned commands_queued = 0;

	checked_handle_table DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.object_value  (object_value),
		.slot_index    (slot_index),
		.handle_ident  (handle_ident),
		.done          (done),
		.result_object (result_object),
		.new_ident     (new_ident),
		.new_slot      (new_slot),
		.status        (status)
	);

	always #10 clk = ~clk;

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50) $display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic apply_table_command(input logic [FUNC_W-1:0] op,
			input logic [OBJECT_WIDTH-1:0] obj, input logic [SLOT_W-1:0] slot,
			input logic [IDENT_WIDTH-1:0] ident);
		table_reply_t r;
		r.object_word = '0;
		r.ident = '0;
		r.slot = '0;
		r.status = ST_MISMATCH;
		case (op)
		FUNC_CREATE: begin
			if (lowest_free >= TABLE_DEPTH) begin
				r.status = ST_FULL;
				full_rejects++;
			end else begin
				r.status = ST_OK;
				r.ident = next_ident;
				r.slot = lowest_free[SLOT_W-1:0];
				occupied[lowest_free] = 1'b1;
				ever_written[lowest_free] = 1'b1;
				stored_ident[lowest_free] = next_ident;
				stored_object[lowest_free] = obj;
				occupied_count++;
				next_ident = next_ident + 1'b1;
				if (next_ident == '0) next_ident = 1;
				while (lowest_free < TABLE_DEPTH && occupied[lowest_free]) lowest_free++;
			end
		end
		FUNC_LOOKUP: begin
			if (ident == '0) begin
				r.status = ST_DETACHED;
			end else if (occupied[slot] && stored_ident[slot] == ident) begin
				r.status = ST_OK;
				r.object_word = stored_object[slot];
			end
		end
		FUNC_REMOVE: begin
			if (occupied[slot] && stored_ident[slot] == ident) begin
				r.status = ST_OK;
				r.object_word = stored_object[slot];
				occupied[slot] = 1'b0;
				occupied_count--;
				if (slot < lowest_free) lowest_free = slot;
			end
		end
		default: ;
		endcase
		expected_replies.push_back(r);
	endtask

	task automatic check_reply();
		table_reply_t want;
		if (expected_replies.size() == 0) begin
			log_mismatch("result beat with no command outstanding");
		end else begin
			want = expected_replies.pop_front();
			if (result_object !== want.object_word || new_ident !== want.ident ||
					new_slot !== want.slot || status !== want.status)
				log_mismatch($sformatf(
					"got obj %h id %h slot %0d st %0d, want obj %h id %h slot %0d st %s",
					result_object, new_ident, new_slot, status,
					want.object_word, want.ident, want.slot, want.status.name()));
		end
	endtask

	// driver: hold a command until accepted, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (pending_commands.size() != 0 &&
					$urandom_range(99) >= pending_commands[0].idle_pct) begin
				next_command = pending_commands.pop_front();
				start <= 1'b1;
				func <= next_command.func;
				object_value <= next_command.object_word;
				slot_index <= next_command.slot;
				handle_ident <= next_command.ident;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check the result beat, then predict the accepted command
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) check_reply();
			if (start && !busy) apply_table_command(func, object_value, slot_index, handle_ident);
		end
	end

	task automatic queue_command(input logic [FUNC_W-1:0] op,
			input logic [OBJECT_WIDTH-1:0] obj, input logic [SLOT_W-1:0] slot,
			input logic [IDENT_WIDTH-1:0] ident);
		table_command_t c;
		while (pending_commands.size() >= 2) @(negedge clk);
		c.func = op;
		c.object_word = obj;
		c.slot = slot;
		c.ident = ident;
		c.idle_pct = commands_queued < 284 ? 34 : (commands_queued < 567 ? 73 : 0);
		pending_commands.push_back(c);
		commands_queued++;
	endtask

	function automatic logic [SLOT_W-1:0] find_slot(input bit want_live);
		int unsigned first;
		int unsigned idx;
		first = $urandom_range(TABLE_DEPTH - 1);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			idx = (first + k) % TABLE_DEPTH;
			if (want_live ? occupied[idx] : ever_written[idx]) return idx[SLOT_W-1:0];
		end
		return first[SLOT_W-1:0];
	endfunction

	task automatic queue_random(input bit filling);
		int unsigned roll;
		logic [FUNC_W-1:0] op;
		logic [OBJECT_WIDTH-1:0] obj;
		logic [SLOT_W-1:0] slot;
		logic [IDENT_WIDTH-1:0] ident;
		roll = $urandom_range(99);
		if (filling)
			op = roll < 75 ? FUNC_CREATE : roll < 88 ? FUNC_LOOKUP :
				roll < 97 ? FUNC_REMOVE : FUNC_UNUSED;
		else
			op = roll < 55 ? FUNC_REMOVE : roll < 85 ? FUNC_LOOKUP :
				roll < 97 ? FUNC_CREATE : FUNC_UNUSED;
		case ($urandom_range(9))
		0: obj = '0;
		1: obj = '1;
		default: obj = {$urandom, $urandom};
		endcase
		if (occupied_count != 0 && $urandom_range(99) < 80) begin
			slot = find_slot(1'b1);
			ident = stored_ident[slot];
		end else begin
			slot = find_slot(1'b0);
			case ($urandom_range(3))
			0: ident = '0;
			1: ident = $urandom;
			2: ident = stored_ident[slot] + 1'b1;
			default: ident = stored_ident[slot];
			endcase
		end
		queue_command(op, obj, slot, ident);
	endtask

	initial begin
		bit filling;
		int unsigned rejects_at_full;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_command(FUNC_CREATE, '1, 7'd0, 32'd0);
		queue_command(FUNC_CREATE, '0, 7'd127, 32'd0);
		queue_command(FUNC_CREATE, 64'h0123_4567_89ab_cdef, 7'd0, '1);
		queue_command(FUNC_UNUSED, '1, 7'd0, '1);
		queue_command(FUNC_LOOKUP, '0, 7'd0, 32'd1);
		queue_command(FUNC_LOOKUP, '1, 7'd1, 32'd2);
		queue_command(FUNC_LOOKUP, '0, 7'd0, 32'd2);
		queue_command(FUNC_LOOKUP, '0, 7'd0, 32'd0);
		queue_command(FUNC_LOOKUP, '0, 7'd2, '1);
		queue_command(FUNC_REMOVE, '0, 7'd0, 32'd0);
		queue_command(FUNC_REMOVE, '0, 7'd1, 32'd3);
		queue_command(FUNC_REMOVE, '0, 7'd1, 32'd2);
		queue_command(FUNC_LOOKUP, '0, 7'd1, 32'd2);
		queue_command(FUNC_REMOVE, '0, 7'd1, 32'd2);
		queue_command(FUNC_REMOVE, '0, 7'd0, 32'd1);
		queue_command(FUNC_CREATE, {$urandom, $urandom}, 7'd1, 32'd0);
		queue_command(FUNC_CREATE, {$urandom, $urandom}, 7'd2, 32'd0);
		queue_command(FUNC_CREATE, 64'h8000_0000_0000_0001, 7'd0, 32'd0);
		queue_command(FUNC_REMOVE, '0, 7'd2, 32'd3);
		queue_command(FUNC_CREATE, {$urandom, $urandom}, 7'd0, 32'd0);
		queue_command(FUNC_LOOKUP, '0, 7'd3, 32'd6);
		queue_command(FUNC_UNUSED, '0, 7'd0, '0);

		filling = 1'b1;
		rejects_at_full = 0;
		for (int n = 0; n < RANDOM_COMMANDS; n++) begin
			if (filling && occupied_count < TABLE_DEPTH) rejects_at_full = full_rejects;
			if (filling && full_rejects >= rejects_at_full + 4) filling = 1'b0;
			else if (!filling && occupied_count < 6) filling = 1'b1;
			queue_random(filling);
		end

		while (pending_commands.size() != 0 || start) @(posedge clk);
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
